// File: design/i2cram_pkg.sv
`default_nettype none

package i2cram_pkg;

	localparam int unsigned DEV_ADDR_W = 7;
	localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'd105;

	// bus phase of the sequencer
	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST_CHECK,
		PH_ST_FALL,
		PH_ST_HOLD,
		PH_TX_LO,
		PH_TX_HI,
		PH_ACK_LO,
		PH_ACK_HI,
		PH_RS_LOW,
		PH_RS_CHECK,
		PH_RS_FALL,
		PH_RS_HOLD,
		PH_RD_LO,
		PH_RD_HI,
		PH_NACK_LO,
		PH_NACK_HI,
		PH_SP_LO,
		PH_SP_HI,
		PH_SP_REL
	} phase_t;

	// byte being shifted out
	typedef enum logic [1:0] {
		BYTE_ADDR_W,
		BYTE_REG,
		BYTE_DATA,
		BYTE_ADDR_R
	} byte_sel_t;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_BUS_BUSY  = 2'd1;
	localparam logic [1:0] ERR_NO_START  = 2'd2;
	localparam logic [1:0] ERR_ADDR_NACK = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef struct packed {
		phase_t    phase;
		byte_sel_t byte_sel;
		logic [2:0] bit_count;
		logic [7:0] shift_reg;
		logic       is_read;
		logic [7:0] reg_latch;
		logic [7:0] data_latch;
		logic [1:0] err_latch;
	} seq_state_t;

	typedef struct packed {
		logic       request;
		logic       command;
		logic [7:0] reg_index;
		logic [7:0] write_byte;
		logic       sda_level;
	} phase_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [1:0] error_code;
		logic [7:0] read_byte;
	} phase_res_t;

endpackage

`default_nettype wire

// File: design/i2c_register_access_master_unit.sv
// an accepted phase item is captured in the input register, stepped, and its result captured in the result register
// throughput: one phase item per cycle; while a result is held off the input register
//   takes one more item, then in_ready stays low until the result is taken
// the sequencer step between the two registers is one pass of short logic
// reset (arst_n low, asynchronous): sequencer idle, pipeline empty, device address 105
`default_nettype none

module i2c_register_access_master_unit (
	input  wire  logic                              clk,
	input  wire  logic                              arst_n,
	// device address register
	input  wire  logic                              cfg_we,
	input  wire  logic [i2cram_pkg::DEV_ADDR_W-1:0] cfg_wdata,
	// phase item channel
	input  wire  logic                              in_valid,
	output logic                                    in_ready,
	input  wire  logic                              request,
	input  wire  logic                              command,
	input  wire  logic [7:0]                        reg_index,
	input  wire  logic [7:0]                        write_byte,
	input  wire  logic                              sda_level,
	// phase result channel
	output logic                                    out_valid,
	input  wire  logic                              out_ready,
	output logic                                    scl_level,
	output logic                                    sda_release,
	output logic                                    busy_res,
	output logic                                    done_res,
	output logic [1:0]                              error_code,
	output logic [7:0]                              read_byte
);
	import i2cram_pkg::*;

	logic [DEV_ADDR_W-1:0] dev_addr_q;

	// input stage
	logic        valid_s1;
	phase_item_t item_s1;

	// sequencer state, updated once per phase item
	seq_state_t  state_q;
	seq_state_t  state_d;
	phase_res_t  res;

	// result stage
	logic        valid_s2;
	phase_res_t  res_s2;

	logic        advance;

	// item moves from the input stage into the result stage when there is room
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// device address; the user must write it only between transactions, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (cfg_we) begin
			dev_addr_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.request    <= request;
			item_s1.command    <= command;
			item_s1.reg_index  <= reg_index;
			item_s1.write_byte <= write_byte;
			item_s1.sda_level  <= sda_level;
		end
	end

	// one bus phase of the transaction sequencer
	i2cram_step u_step (
		.state_q  (state_q),
		.item     (item_s1),
		.dev_addr (dev_addr_q),
		.state_d  (state_d),
		.res      (res)
	);

	// sequencer state only moves when its phase result is captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_IDLE;
			state_q.byte_sel   <= BYTE_ADDR_W;
			state_q.bit_count  <= 3'd0;
			state_q.shift_reg  <= 8'd0;
			state_q.is_read    <= 1'b0;
			state_q.reg_latch  <= 8'd0;
			state_q.data_latch <= 8'd0;
			state_q.err_latch  <= ERR_NONE;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign scl_level   = res_s2.scl_level;
	assign sda_release = res_s2.sda_release;
	assign busy_res    = res_s2.busy_res;
	assign done_res    = res_s2.done_res;
	assign error_code  = res_s2.error_code;
	assign read_byte   = res_s2.read_byte;

endmodule

`default_nettype wire

// File: design/i2cram_step.sv
`default_nettype none

module i2cram_step (
	input  wire  i2cram_pkg::seq_state_t          state_q,
	input  wire  i2cram_pkg::phase_item_t         item,
	input  wire  logic [i2cram_pkg::DEV_ADDR_W-1:0] dev_addr,
	output i2cram_pkg::seq_state_t                state_d,
	output i2cram_pkg::phase_res_t                res
);
	import i2cram_pkg::*;

	logic       start;
	phase_t     eff_phase;
	seq_state_t base;

	// load the shifter with the next byte and go to its first bit
	function automatic seq_state_t begin_send(seq_state_t s, byte_sel_t k,
	                                          logic [DEV_ADDR_W-1:0] addr);
		seq_state_t r;
		r = s;
		unique case (k)
			BYTE_ADDR_W: r.shift_reg = {addr, 1'b0};
			BYTE_REG:    r.shift_reg = s.reg_latch;
			BYTE_DATA:   r.shift_reg = s.data_latch;
			BYTE_ADDR_R: r.shift_reg = {addr, 1'b1};
			default:     r.shift_reg = s.reg_latch;
		endcase
		r.bit_count = 3'd0;
		r.byte_sel  = k;
		r.phase     = PH_TX_LO;
		return r;
	endfunction

	// a request in idle latches the transaction and runs its start check now
	always_comb begin
		start     = (state_q.phase == PH_IDLE) && item.request;
		eff_phase = start ? PH_ST_CHECK : state_q.phase;
		base      = state_q;
		if (start) begin
			base.is_read    = (item.command == CMD_READ);
			base.reg_latch  = item.reg_index;
			base.data_latch = item.write_byte;
			base.err_latch  = ERR_NONE;
			base.bit_count  = 3'd0;
		end
	end

	// next state
	always_comb begin
		state_d = base;
		unique case (eff_phase)
			PH_IDLE: state_d.phase = PH_IDLE;
			PH_ST_CHECK: begin
				if (!item.sda_level) begin
					state_d.err_latch = ERR_BUS_BUSY;
					state_d.phase     = PH_IDLE;
				end else begin
					state_d.phase = PH_ST_FALL;
				end
			end
			PH_ST_FALL: begin
				if (item.sda_level) begin
					state_d.err_latch = ERR_NO_START;
					state_d.phase     = PH_IDLE;
				end else begin
					state_d.phase = PH_ST_HOLD;
				end
			end
			PH_ST_HOLD: state_d = begin_send(base, BYTE_ADDR_W, dev_addr);
			PH_TX_LO:   state_d.phase = PH_TX_HI;
			PH_TX_HI: begin
				if (base.bit_count == 3'd7) begin
					state_d.bit_count = 3'd0;
					state_d.phase     = PH_ACK_LO;
				end else begin
					state_d.shift_reg = {base.shift_reg[6:0], 1'b0};
					state_d.bit_count = base.bit_count + 3'd1;
					state_d.phase     = PH_TX_LO;
				end
			end
			PH_ACK_LO: state_d.phase = PH_ACK_HI;
			PH_ACK_HI: begin
				unique case (base.byte_sel)
					BYTE_ADDR_W: begin
						if (item.sda_level) begin
							state_d.err_latch = ERR_ADDR_NACK;
							state_d.phase     = PH_SP_LO;
						end else begin
							state_d = begin_send(base, BYTE_REG, dev_addr);
						end
					end
					BYTE_REG: begin
						if (base.is_read) state_d.phase = PH_RS_LOW;
						else state_d = begin_send(base, BYTE_DATA, dev_addr);
					end
					BYTE_DATA: state_d.phase = PH_SP_LO;
					BYTE_ADDR_R: begin
						state_d.shift_reg = 8'd0;
						state_d.bit_count = 3'd0;
						state_d.phase     = PH_RD_LO;
					end
					default: state_d.phase = PH_SP_LO;
				endcase
			end
			PH_RS_LOW:   state_d.phase = PH_RS_CHECK;
			PH_RS_CHECK: state_d.phase = PH_RS_FALL;
			PH_RS_FALL:  state_d.phase = PH_RS_HOLD;
			PH_RS_HOLD:  state_d = begin_send(base, BYTE_ADDR_R, dev_addr);
			PH_RD_LO:    state_d.phase = PH_RD_HI;
			PH_RD_HI: begin
				state_d.shift_reg = {base.shift_reg[6:0], item.sda_level};
				if (base.bit_count == 3'd7) begin
					state_d.bit_count = 3'd0;
					state_d.phase     = PH_NACK_LO;
				end else begin
					state_d.bit_count = base.bit_count + 3'd1;
					state_d.phase     = PH_RD_LO;
				end
			end
			PH_NACK_LO: state_d.phase = PH_NACK_HI;
			PH_NACK_HI: state_d.phase = PH_SP_LO;
			PH_SP_LO:   state_d.phase = PH_SP_HI;
			PH_SP_HI:   state_d.phase = PH_SP_REL;
			PH_SP_REL:  state_d.phase = PH_IDLE;
			default:    state_d.phase = PH_IDLE;
		endcase
	end

	// bus levels and status for this phase
	always_comb begin
		res.scl_level   = 1'b1;
		res.sda_release = 1'b1;
		res.busy_res    = 1'b1;
		res.done_res    = 1'b0;
		unique case (eff_phase)
			PH_IDLE:     res.busy_res = 1'b0;
			PH_ST_CHECK: res.done_res = !item.sda_level;
			PH_ST_FALL: begin
				res.sda_release = 1'b0;
				res.done_res    = item.sda_level;
			end
			PH_ST_HOLD:  res.sda_release = 1'b0;
			PH_TX_LO: begin
				res.scl_level   = 1'b0;
				res.sda_release = base.shift_reg[7];
			end
			PH_TX_HI:    res.sda_release = base.shift_reg[7];
			PH_ACK_LO:   res.scl_level = 1'b0;
			PH_ACK_HI:   res.scl_level = 1'b1;
			PH_RS_LOW:   res.scl_level = 1'b0;
			PH_RS_CHECK: res.scl_level = 1'b1;
			PH_RS_FALL:  res.sda_release = 1'b0;
			PH_RS_HOLD:  res.sda_release = 1'b0;
			PH_RD_LO:    res.scl_level = 1'b0;
			PH_RD_HI:    res.scl_level = 1'b1;
			PH_NACK_LO:  res.scl_level = 1'b0;
			PH_NACK_HI:  res.scl_level = 1'b1;
			PH_SP_LO: begin
				res.scl_level   = 1'b0;
				res.sda_release = 1'b0;
			end
			PH_SP_HI:    res.sda_release = 1'b0;
			PH_SP_REL:   res.done_res = 1'b1;
			default:     res.busy_res = 1'b0;
		endcase
		res.error_code = res.done_res ? state_d.err_latch : ERR_NONE;
		res.read_byte  = (res.done_res && state_d.is_read && state_d.err_latch == ERR_NONE)
		                 ? state_d.shift_reg : 8'd0;
	end

endmodule

`default_nettype wire

// File: design/i2cram_checker.sv
`default_nettype none

module i2cram_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       scl_level,
	input wire logic       sda_release,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic [1:0] error_code,
	input wire logic [7:0] read_byte
);
	import i2cram_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_byte) && $stable(done_res))
		else $error("result changed while stalled");

	// idle phase releases the bus and raises no flag
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> scl_level && sda_release && !done_res
		&& error_code == ERR_NONE && read_byte == 8'd0)
		else $error("idle phase not quiet");

	// an error code only comes with the finishing phase
	a_err_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> done_res && busy_res)
		else $error("error code outside done");

	// read data only on a clean finish, which always ends with both lines high
	a_read_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_byte != 8'd0 |-> done_res && error_code == ERR_NONE
		&& scl_level && sda_release)
		else $error("read data outside clean done");

endmodule

bind i2c_register_access_master_unit i2cram_checker u_checker (.*);

`default_nettype wire

// File: sim/i2cram_tb_pkg.sv
`timescale 1ns / 100ps

package i2cram_tb_pkg;

	import i2cram_pkg::*;

	// tracks the bus sequencer phase by phase and holds the results still owed by the block
	class phase_result_board;
		logic [DEV_ADDR_W-1:0] device_addr;
		phase_t                seq_phase;
		byte_sel_t             seq_byte;
		logic [2:0]            bit_count;
		logic [7:0]            shift_reg;
		logic                  is_read;
		logic [7:0]            reg_latch;
		logic [7:0]            data_latch;
		logic [1:0]            err_latch;
		phase_res_t            due_results[$];
		int unsigned           mismatches;

		function new();
			device_addr = DEV_ADDR_RESET;
			seq_phase   = PH_IDLE;
			seq_byte    = BYTE_ADDR_W;
			bit_count   = '0;
			shift_reg   = '0;
			is_read     = 1'b0;
			reg_latch   = '0;
			data_latch  = '0;
			err_latch   = ERR_NONE;
			mismatches  = 0;
		endfunction

		function void set_addr(logic [DEV_ADDR_W-1:0] addr);
			device_addr = addr;
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		function void load_byte(byte_sel_t sel);
			case (sel)
				BYTE_ADDR_W: shift_reg = {device_addr, 1'b0};
				BYTE_REG:    shift_reg = reg_latch;
				BYTE_DATA:   shift_reg = data_latch;
				default:     shift_reg = {device_addr, 1'b1};
			endcase
			bit_count = '0;
			seq_byte  = sel;
			seq_phase = PH_TX_LO;
		endfunction

		function void note_phase_item(phase_item_t item);
			phase_res_t res;
			logic       scl;
			logic       rel;
			logic       done;
			scl  = 1'b1;
			rel  = 1'b1;
			done = 1'b0;
			if (seq_phase == PH_IDLE) begin
				if (!item.request) begin
					res = '0;
					res.scl_level   = 1'b1;
					res.sda_release = 1'b1;
					due_results.push_back(res);
					return;
				end
				is_read    = item.command;
				reg_latch  = item.reg_index;
				data_latch = item.write_byte;
				err_latch  = ERR_NONE;
				bit_count  = '0;
				seq_phase  = PH_ST_CHECK;
			end
			case (seq_phase)
				PH_ST_CHECK: begin
					if (!item.sda_level) begin
						err_latch = ERR_BUS_BUSY;
						done      = 1'b1;
						seq_phase = PH_IDLE;
					end else
						seq_phase = PH_ST_FALL;
				end
				PH_ST_FALL: begin
					rel = 1'b0;
					if (item.sda_level) begin
						err_latch = ERR_NO_START;
						done      = 1'b1;
						seq_phase = PH_IDLE;
					end else
						seq_phase = PH_ST_HOLD;
				end
				PH_ST_HOLD: begin
					rel = 1'b0;
					load_byte(BYTE_ADDR_W);
				end
				PH_TX_LO: begin
					scl       = 1'b0;
					rel       = shift_reg[7];
					seq_phase = PH_TX_HI;
				end
				PH_TX_HI: begin
					rel = shift_reg[7];
					if (bit_count == 3'd7) begin
						bit_count = '0;
						seq_phase = PH_ACK_LO;
					end else begin
						shift_reg = shift_reg << 1;
						bit_count = bit_count + 3'd1;
						seq_phase = PH_TX_LO;
					end
				end
				PH_ACK_LO: begin
					scl       = 1'b0;
					seq_phase = PH_ACK_HI;
				end
				PH_ACK_HI: begin
					case (seq_byte)
						BYTE_ADDR_W: begin
							if (item.sda_level) begin
								err_latch = ERR_ADDR_NACK;
								seq_phase = PH_SP_LO;
							end else
								load_byte(BYTE_REG);
						end
						BYTE_REG: begin
							if (is_read)
								seq_phase = PH_RS_LOW;
							else
								load_byte(BYTE_DATA);
						end
						BYTE_DATA: seq_phase = PH_SP_LO;
						default: begin
							shift_reg = '0;
							bit_count = '0;
							seq_phase = PH_RD_LO;
						end
					endcase
				end
				PH_RS_LOW: begin
					scl       = 1'b0;
					seq_phase = PH_RS_CHECK;
				end
				PH_RS_CHECK: seq_phase = PH_RS_FALL;
				PH_RS_FALL: begin
					rel       = 1'b0;
					seq_phase = PH_RS_HOLD;
				end
				PH_RS_HOLD: begin
					rel = 1'b0;
					load_byte(BYTE_ADDR_R);
				end
				PH_RD_LO: begin
					scl       = 1'b0;
					seq_phase = PH_RD_HI;
				end
				PH_RD_HI: begin
					shift_reg = {shift_reg[6:0], item.sda_level};
					if (bit_count == 3'd7) begin
						bit_count = '0;
						seq_phase = PH_NACK_LO;
					end else begin
						bit_count = bit_count + 3'd1;
						seq_phase = PH_RD_LO;
					end
				end
				PH_NACK_LO: begin
					scl       = 1'b0;
					seq_phase = PH_NACK_HI;
				end
				PH_NACK_HI: seq_phase = PH_SP_LO;
				PH_SP_LO: begin
					scl       = 1'b0;
					rel       = 1'b0;
					seq_phase = PH_SP_HI;
				end
				PH_SP_HI: begin
					rel       = 1'b0;
					seq_phase = PH_SP_REL;
				end
				default: begin
					done      = 1'b1;
					seq_phase = PH_IDLE;
				end
			endcase
			res.scl_level   = scl;
			res.sda_release = rel;
			res.busy_res    = 1'b1;
			res.done_res    = done;
			res.error_code  = done ? err_latch : ERR_NONE;
			res.read_byte   = (done && is_read && err_latch == ERR_NONE) ? shift_reg : 8'h00;
			due_results.push_back(res);
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_phase_result(phase_res_t got);
			phase_res_t want;
			if (due_results.size() == 0) begin
				$error("result with no transaction outstanding");
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			compare_field("scl_level", want.scl_level, got.scl_level);
			compare_field("sda_release", want.sda_release, got.sda_release);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("error_code", want.error_code, got.error_code);
			compare_field("read_byte", want.read_byte, got.read_byte);
		endfunction
	endclass

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	import i2cram_pkg::*;
	import i2cram_tb_pkg::*;

	// how the simulated target answers a transaction
	typedef enum {
		FAULT_NONE,
		FAULT_BUS_BUSY,
		FAULT_NO_START,
		FAULT_ADDR_NACK
	} fault_t;

	localparam int STALL_LIMIT   = 2000;	// cycles without any transaction before giving up
	localparam int HOLD_CYCLES   = 400;		// long receiver hold-off for the pressure test
	localparam int RANDOM_ITEMS  = 250;
	localparam int SETTING_COUNT = 5;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [DEV_ADDR_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  request = 1'b0;
	logic                  command = 1'b0;
	logic [7:0]            reg_index = '0;
	logic [7:0]            write_byte = '0;
	logic                  sda_level = 1'b1;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  scl_level;
	logic                  sda_release;
	logic                  busy_res;
	logic                  done_res;
	logic [1:0]            error_code;
	logic [7:0]            read_byte;

	// shared between the stimulus and the two handshake processes
	bit          calm = 1'b0;			// no idling on either side
	bit          stall_request = 1'b0;	// ask the result side for one long hold-off
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;
	phase_res_t  seen_result;

	phase_result_board board = new();

	i2c_register_access_master_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.request    (request),
		.command    (command),
		.reg_index  (reg_index),
		.write_byte (write_byte),
		.sda_level  (sda_level),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.scl_level  (scl_level),
		.sda_release(sda_release),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.error_code (error_code),
		.read_byte  (read_byte)
	);

	always #1 clk = ~clk;

	// offer one phase item and block until the block takes it; the predictor
	// advances at the same edge, so the caller sees the new sequencer phase
	task automatic send_item(input phase_item_t item);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		request    <= item.request;
		command    <= item.command;
		reg_index  <= item.reg_index;
		write_byte <= item.write_byte;
		sda_level  <= item.sda_level;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_phase_item(item);
		items_sent++;
	endtask

	// one whole bus transaction from the idle state back to idle; the target's
	// sda answers follow the fault plan, everything the sequencer ignores is random
	task automatic run_txn(input logic cmd, input logic [7:0] reg_b, input logic [7:0] wr_b,
			input fault_t fault, input logic [7:0] target_b, input bit noisy);
		phase_item_t item;
		phase_t      at;
		logic [2:0]  rd_bit;
		bit          first;
		rd_bit = 3'd7;
		first  = 1'b1;
		do begin
			at              = first ? PH_ST_CHECK : board.seq_phase;
			// request and the latched fields only matter in the first phase
			item.request    = first ? 1'b1 : 1'($urandom_range(1));
			item.command    = first ? cmd : 1'($urandom_range(1));
			item.reg_index  = first ? reg_b : 8'($urandom_range(255));
			item.write_byte = first ? wr_b : 8'($urandom_range(255));
			item.sda_level  = 1'($urandom_range(1));
			case (at)
				PH_ST_CHECK: item.sda_level = (fault != FAULT_BUS_BUSY);
				PH_ST_FALL:  item.sda_level = (fault == FAULT_NO_START);
				PH_ACK_HI: begin
					// only the address+W acknowledge is looked at
					if (board.seq_byte == BYTE_ADDR_W)
						item.sda_level = (fault == FAULT_ADDR_NACK);
				end
				PH_RD_HI: begin
					item.sda_level = target_b[rd_bit];
					rd_bit         = rd_bit - 3'd1;
				end
				default: ;
			endcase
			// glitchy bus: the plan may be broken anywhere
			if (noisy && $urandom_range(3) == 0)
				item.sda_level = 1'($urandom_range(1));
			send_item(item);
			first = 1'b0;
		end while (board.seq_phase != PH_IDLE);
	endtask

	task automatic idle_noise();
		phase_item_t item;
		item.request    = 1'b0;
		item.command    = 1'($urandom_range(1));
		item.reg_index  = 8'($urandom_range(255));
		item.write_byte = 8'($urandom_range(255));
		item.sda_level  = 1'($urandom_range(1));
		send_item(item);
	endtask

	task automatic random_txn();
		int     roll;
		fault_t fault;
		roll = $urandom_range(99);
		if (roll < 10) begin
			repeat ($urandom_range(1, 4))
				idle_noise();
		end else begin
			// mostly clean transactions, the rest broken at the start or the address
			fault = (roll < 18) ? FAULT_BUS_BUSY :
				(roll < 26) ? FAULT_NO_START :
				(roll < 36) ? FAULT_ADDR_NACK : FAULT_NONE;
			run_txn($urandom_range(1) ? CMD_READ : CMD_WRITE, 8'($urandom_range(255)),
				8'($urandom_range(255)), fault, 8'($urandom_range(255)),
				$urandom_range(9) == 0);
		end
	endtask

	// stop offering and wait until every owed result has come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	// address changes only with the sequencer idle and nothing in flight
	task automatic set_device_addr(input logic [DEV_ADDR_W-1:0] addr);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= addr;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_addr(addr);
	endtask

	// result side: random back-pressure, one long hold-off on request
	initial begin : result_sink
		forever begin
			@(negedge clk);
			if (stall_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				stall_request = 1'b0;
			end
			out_ready <= calm || $urandom_range(99) >= 37;
		end
	end

	// every accepted result goes against the oldest prediction
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			seen_result.scl_level   = scl_level;
			seen_result.sda_release = sda_release;
			seen_result.busy_res    = busy_res;
			seen_result.done_res    = done_res;
			seen_result.error_code  = error_code;
			seen_result.read_byte   = read_byte;
			board.check_phase_result(seen_result);
		end
	end

	// watchdog: a stuck handshake on both sides ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		logic [DEV_ADDR_W-1:0] addr_plan[SETTING_COUNT];
		int unsigned           stop_at;
		phase_item_t           item;
		addr_plan[0] = '0;
		addr_plan[1] = '1;
		addr_plan[2] = 7'h55;
		addr_plan[3] = 7'h2A;
		addr_plan[4] = 7'($urandom_range(127));

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, at the reset address
		// idle phases with every ignored field at both extremes
		item = '1;
		item.request   = 1'b0;
		item.sda_level = 1'b0;
		send_item(item);
		item = '0;
		item.sda_level = 1'b1;
		send_item(item);
		// clean write and reads with extreme register, data and returned bytes
		run_txn(CMD_WRITE, 8'hFF, 8'h00, FAULT_NONE, 8'h00, 1'b0);
		run_txn(CMD_WRITE, 8'h00, 8'hFF, FAULT_NONE, 8'h00, 1'b0);
		run_txn(CMD_READ, 8'h00, 8'hFF, FAULT_NONE, 8'hA5, 1'b0);
		run_txn(CMD_READ, 8'h80, 8'h01, FAULT_NONE, 8'hFF, 1'b0);
		run_txn(CMD_READ, 8'h01, 8'h80, FAULT_NONE, 8'h00, 1'b0);
		// bus held low before the start
		run_txn(CMD_WRITE, 8'h5A, 8'hC3, FAULT_BUS_BUSY, 8'h00, 1'b0);
		// start condition never shows on sda
		run_txn(CMD_READ, 8'h3C, 8'h96, FAULT_NO_START, 8'hFF, 1'b0);
		// no target at the address, for both kinds
		run_txn(CMD_WRITE, 8'h12, 8'h34, FAULT_ADDR_NACK, 8'h00, 1'b0);
		run_txn(CMD_READ, 8'h56, 8'h78, FAULT_ADDR_NACK, 8'hFF, 1'b0);

		// random part, split over several device addresses
		stop_at = items_sent;
		for (int s = 0; s < SETTING_COUNT; s++) begin
			set_device_addr(addr_plan[s]);
			calm = (s == 2);
			// the receiver goes quiet while items keep coming, so the block backs up
			if (s == 1)
				stall_request = 1'b1;
			stop_at = stop_at + RANDOM_ITEMS / SETTING_COUNT;
			while (items_sent < stop_at)
				random_txn();
		end
		calm = 1'b0;

		settle();
		// late or extra results would show up here
		repeat (10)
			@(posedge clk);
		if (board.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
